FILE: hdl/assert_macros.svh
// Assertion macros shared by the queue RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/ideq_pkg.sv
// Package: sizes, action and status codes and the command type of the indexed deque.
`timescale 1ns / 1ps

package ideq_pkg;

  // Ring store geometry; DEPTH is a power of two so ring indices wrap by truncation
  localparam int DEPTH  = 256;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 4;
  localparam int POS_W  = 8;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS   = ACT_W + DATA_W + POS_W;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = DATA_W + CNT_W + 2;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_TAIL = 4'd0,
    ACT_PUSH_HEAD = 4'd1,
    ACT_POP_TAIL  = 4'd2,
    ACT_POP_HEAD  = 4'd3,
    ACT_READ      = 4'd4,
    ACT_WRITE     = 4'd5,
    ACT_INSERT    = 4'd6,
    ACT_ERASE     = 4'd7,
    ACT_CLEAR     = 4'd8,
    ACT_NOP       = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    action_e           kind;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } op_t;

endpackage

FILE: hdl/ideq_front.sv
// Front end: unpacks the input word and classifies its action code.
`timescale 1ns / 1ps

module ideq_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ideq_pkg::IN_TDW-1:0] s_axis_tdata,  // action, value, position
  output logic                        op_valid_o,
  input  logic                        op_ready_i,
  output ideq_pkg::op_t               op_o
);

  logic [ideq_pkg::ACT_W-1:0] act;

  assign act = s_axis_tdata[ideq_pkg::ACT_W-1:0];

  // Map unused action codes onto a no-op
  always_comb begin
    if (act <= ideq_pkg::ACT_CLEAR) begin
      op_o.kind = ideq_pkg::action_e'(act);
    end else begin
      op_o.kind = ideq_pkg::ACT_NOP;
    end
    op_o.value    = s_axis_tdata[ideq_pkg::ACT_W +: ideq_pkg::DATA_W];
    op_o.position = s_axis_tdata[ideq_pkg::ACT_W + ideq_pkg::DATA_W +: ideq_pkg::POS_W];
  end

  assign op_valid_o    = s_axis_tvalid;
  assign s_axis_tready = op_ready_i;

endmodule

FILE: hdl/ideq_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ideq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ideq_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ideq_pkg::op_t pop_op_o
);

  ideq_pkg::op_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Hold commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  `ASSERT_AT(a_fill_bound, clk_i, rst_ni, fill_q <= 2'd2)

endmodule

FILE: hdl/ideq_back.sv
// Back end: ring store, head and count, shift sequencer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ideq_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_valid_i,
  output logic                         op_ready_o,
  input  ideq_pkg::op_t                op_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ideq_pkg::OUT_TDW-1:0] m_axis_tdata   // data, count, status
);

  localparam int PW = ideq_pkg::PTR_W;
  localparam int CW = ideq_pkg::CNT_W;
  localparam int DW = ideq_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_ER_CAP = 3'd2;
  localparam logic [2:0] S_ER_WR  = 3'd3;
  localparam logic [2:0] S_IN_WR  = 3'd4;
  localparam logic [2:0] S_IN_FIN = 3'd5;

  logic [DW-1:0] mem [ideq_pkg::DEPTH];
  logic [DW-1:0] rdata_q;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] k_q, k_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [DW-1:0] val_q, val_d;
  logic [DW-1:0] hold_q, hold_d;

  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;

  logic              res_valid;
  logic [DW-1:0]     res_data;
  logic [CW-1:0]     res_count;
  ideq_pkg::status_e res_status;

  logic              out_valid_q;
  logic [DW-1:0]     out_data_q;
  logic [CW-1:0]     out_count_q;
  ideq_pkg::status_e out_status_q;

  logic          out_free, start, full, empty, pos_lt, pos_eq;
  logic [CW-1:0] pos_ext;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign start      = (state_q == S_IDLE) && op_valid_i && out_free;
  assign op_ready_o = start;
  assign full       = (count_q == CW'(ideq_pkg::DEPTH));
  assign empty      = (count_q == '0);
  assign pos_ext    = CW'(op_i.position);
  assign pos_lt     = (pos_ext < count_q);
  assign pos_eq     = (pos_ext == count_q);

  // Sequence each command over the ring store, which has one write port and one read port
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    k_d        = k_q;
    pos_d      = pos_q;
    val_d      = val_q;
    hold_d     = hold_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    res_valid  = 1'b0;
    res_data   = '0;
    res_count  = count_q;
    res_status = ideq_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_valid = 1'b1;
          unique case (op_i.kind)
            ideq_pkg::ACT_PUSH_TAIL: begin
              if (full) begin
                res_status = ideq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = head_q + count_q[PW-1:0];
                wr_data   = op_i.value;
                count_d   = count_q + CW'(1);
                res_count = count_d;
              end
            end
            ideq_pkg::ACT_PUSH_HEAD: begin
              if (full) begin
                res_status = ideq_pkg::ST_FULL;
              end else begin
                head_d    = head_q - PW'(1);
                wr_en     = 1'b1;
                wr_addr   = head_d;
                wr_data   = op_i.value;
                count_d   = count_q + CW'(1);
                res_count = count_d;
              end
            end
            ideq_pkg::ACT_POP_TAIL: begin
              if (empty) begin
                res_status = ideq_pkg::ST_EMPTY;
              end else begin
                res_valid = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = head_q + count_q[PW-1:0] - PW'(1);
                count_d   = count_q - CW'(1);
                state_d   = S_RD;
              end
            end
            ideq_pkg::ACT_POP_HEAD: begin
              if (empty) begin
                res_status = ideq_pkg::ST_EMPTY;
              end else begin
                res_valid = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = head_q;
                head_d    = head_q + PW'(1);
                count_d   = count_q - CW'(1);
                state_d   = S_RD;
              end
            end
            ideq_pkg::ACT_READ: begin
              if (!pos_lt) begin
                res_status = ideq_pkg::ST_RANGE;
              end else begin
                res_valid = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = head_q + op_i.position;
                state_d   = S_RD;
              end
            end
            ideq_pkg::ACT_WRITE: begin
              if (!pos_lt) begin
                res_status = ideq_pkg::ST_RANGE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = head_q + op_i.position;
                wr_data = op_i.value;
              end
            end
            ideq_pkg::ACT_INSERT: begin
              if (full) begin
                res_status = ideq_pkg::ST_FULL;
              end else if (!pos_lt && !pos_eq) begin
                res_status = ideq_pkg::ST_RANGE;
              end else if (pos_eq) begin
                // Insert at the end appends
                wr_en     = 1'b1;
                wr_addr   = head_q + count_q[PW-1:0];
                wr_data   = op_i.value;
                count_d   = count_q + CW'(1);
                res_count = count_d;
              end else begin
                // Start moving the tail back from the last element
                res_valid = 1'b0;
                rd_en     = 1'b1;
                k_d       = count_q[PW-1:0] - PW'(1);
                rd_addr   = head_q + k_d;
                pos_d     = op_i.position;
                val_d     = op_i.value;
                state_d   = S_IN_WR;
              end
            end
            ideq_pkg::ACT_ERASE: begin
              if (!pos_lt) begin
                res_status = ideq_pkg::ST_RANGE;
              end else begin
                res_valid = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = head_q + op_i.position;
                k_d       = op_i.position;
                state_d   = S_ER_CAP;
              end
            end
            ideq_pkg::ACT_CLEAR: begin
              count_d   = '0;
              head_d    = '0;
              res_count = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        res_valid = 1'b1;
        res_data  = rdata_q;
        state_d   = S_IDLE;
      end
      S_IN_WR: begin
        // Move one element back; read the next one down meanwhile
        wr_en   = 1'b1;
        wr_addr = head_q + k_q + PW'(1);
        wr_data = rdata_q;
        if (k_q != pos_q) begin
          rd_en   = 1'b1;
          k_d     = k_q - PW'(1);
          rd_addr = head_q + k_d;
        end else begin
          state_d = S_IN_FIN;
        end
      end
      S_IN_FIN: begin
        wr_en     = 1'b1;
        wr_addr   = head_q + pos_q;
        wr_data   = val_q;
        count_d   = count_q + CW'(1);
        res_valid = 1'b1;
        res_count = count_d;
        state_d   = S_IDLE;
      end
      S_ER_CAP: begin
        // Keep the erased element, then close the gap
        hold_d = rdata_q;
        if ((CW'(k_q) + CW'(1)) < count_q) begin
          rd_en   = 1'b1;
          rd_addr = head_q + k_q + PW'(1);
          state_d = S_ER_WR;
        end else begin
          count_d   = count_q - CW'(1);
          res_valid = 1'b1;
          res_data  = rdata_q;
          res_count = count_d;
          state_d   = S_IDLE;
        end
      end
      S_ER_WR: begin
        wr_en   = 1'b1;
        wr_addr = head_q + k_q;
        wr_data = rdata_q;
        k_d     = k_q + PW'(1);
        if ((CW'(k_q) + CW'(2)) < count_q) begin
          rd_en   = 1'b1;
          rd_addr = head_q + k_q + PW'(2);
        end else begin
          count_d   = count_q - CW'(1);
          res_valid = 1'b1;
          res_data  = hold_q;
          res_count = count_d;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    hold_q <= hold_d;
    if (res_valid) begin
      out_data_q   <= res_data;
      out_count_q  <= res_count;
      out_status_q <= res_status;
    end
  end

  // Ring store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ideq_pkg::OUT_TDW'({out_status_q, out_count_q, out_data_q});

  `ASSERT_AT(a_count_bound, clk_i, rst_ni, count_q <= CW'(ideq_pkg::DEPTH))
  `ASSERT_AT(a_busy_out_empty, clk_i, rst_ni, (state_q != S_IDLE) |-> !out_valid_q)
  `ASSERT_AT(a_ins_room, clk_i, rst_ni, (state_q == S_IN_FIN) |-> (count_q < CW'(ideq_pkg::DEPTH)))
  `ASSERT_NEVER(a_res_blocked, clk_i, rst_ni, res_valid && !out_free)

endmodule

FILE: hdl/indexed_double_ended_queue_top.sv
// Top level of the indexed double-ended queue: front end, command queue, back end.
//
//  channel  | dir | tdata fields (low bit up)              | bits
//  s_axis   | in  | action[3:0] value[35:4] position[43:36] | 48
//  m_axis   | out | data[31:0] count[40:32] status[42:41]   | 48
//
// Back end: push, write, clear, no-op, insert at the end and rejected actions finish as taken;
// pops and reads wait on the registered store read; insert at p < count moves p..last up one,
// erase at p moves the ones after p down; the single write port moves one element a cycle.
// A result waits in an output register; the back end starts no word until it is free or taken.
// The command queue holds two words, so the input stalls only when both are waiting.
// Reset (rst_ni low) empties the queue and sets count and head to zero; the store is not cleared.
`timescale 1ns / 1ps

module indexed_double_ended_queue_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ideq_pkg::IN_TDW-1:0]  s_axis_tdata,   // action, value, position
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ideq_pkg::OUT_TDW-1:0] m_axis_tdata    // data, count, status
);

  logic          fe_valid, fe_ready;
  ideq_pkg::op_t fe_op;
  logic          be_valid, be_ready;
  ideq_pkg::op_t be_op;

  ideq_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .op_valid_o    (fe_valid),
    .op_ready_i    (fe_ready),
    .op_o          (fe_op)
  );

  ideq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_op_i    (fe_op),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_op_o     (be_op)
  );

  ideq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (be_valid),
    .op_ready_o    (be_ready),
    .op_i          (be_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
